[hw/rtl/sll_pkg.sv]
// ----------------------------------------------------------------------------
// sll_pkg
// Shared constants and types for the sorted linked list engine.
// ----------------------------------------------------------------------------
package sll_pkg;

   localparam int unsigned SLL_DEPTH = 16;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_EMPTY   = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;

   typedef struct packed {
      logic key_we;
      logic link_we;
      logic free_we;
      logic list_re;
      logic free_re;
   } sll_mem_ctl_type;

endpackage

[hw/rtl/sorted_linked_list_engine_core.sv]
// ----------------------------------------------------------------------------
// sorted_linked_list_engine_core
// Sorted linked list of signed keys in a slot store, with a free slot list.
// ----------------------------------------------------------------------------
// One transaction at a time. A full insert or an empty delete goes straight
// to the result stage. Otherwise the walk steps past one list slot per cycle,
// bounded by the registered read of the key and link memories feeding the
// next address; a missed delete then goes to the result stage, a removal
// unlinks and frees the slot first, an insert at the head writes the new slot
// first, and an insert behind a list slot writes the new slot and then
// relinks its predecessor. The request side is ready again from the edge that
// raises the result, unless an earlier result is still waiting. No clearing
// pass after reset: a fill count stands in for the initial free list.
module sorted_linked_list_engine_core
   import sll_pkg::*;
#(
   parameter int unsigned DEPTH = SLL_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic [0:0]  req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [1:0] status, [5:2] slot, [7:6] zero
);

   localparam int unsigned PW = $clog2(DEPTH + 1);
   localparam int unsigned SW = $clog2(DEPTH);

   sll_mem_ctl_type ctl;
   logic [SW-1:0]   list_raddr;
   logic [SW-1:0]   free_raddr;
   logic [SW-1:0]   key_waddr;
   logic [31:0]     key_wdata;
   logic [SW-1:0]   link_waddr;
   logic [PW-1:0]   link_wdata;
   logic [SW-1:0]   free_waddr;
   logic [PW-1:0]   free_wdata;
   logic [31:0]     key_rd;
   logic [PW-1:0]   link_rd;
   logic [PW-1:0]   free_rd;
   logic [1:0]      rsp_status;
   logic [3:0]      rsp_slot;

   sll_seq #(
      .DEPTH(DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser[0]),
      .req_key    (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot),
      .ctl        (ctl),
      .list_raddr (list_raddr),
      .free_raddr (free_raddr),
      .key_waddr  (key_waddr),
      .key_wdata  (key_wdata),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .free_waddr (free_waddr),
      .free_wdata (free_wdata),
      .key_rd     (key_rd),
      .link_rd    (link_rd),
      .free_rd    (free_rd)
   );

   sll_store #(
      .DEPTH(DEPTH)
   ) u_store (
      .clock      (clock),
      .ctl        (ctl),
      .list_raddr (list_raddr),
      .free_raddr (free_raddr),
      .key_waddr  (key_waddr),
      .key_wdata  (key_wdata),
      .link_waddr (link_waddr),
      .link_wdata (link_wdata),
      .free_waddr (free_waddr),
      .free_wdata (free_wdata),
      .key_rd     (key_rd),
      .link_rd    (link_rd),
      .free_rd    (free_rd)
   );

   assign rsp_tdata = {2'b00, rsp_slot, rsp_status};

endmodule

[hw/rtl/sll_store.sv]
// ----------------------------------------------------------------------------
// sll_store
// Slot store: key, list link and free link memories with registered reads.
// ----------------------------------------------------------------------------
module sll_store
   import sll_pkg::*;
#(
   parameter int unsigned DEPTH = SLL_DEPTH
) (
   input  logic                            clock,
   input  sll_mem_ctl_type                 ctl,
   input  logic [$clog2(DEPTH)-1:0]        list_raddr,
   input  logic [$clog2(DEPTH)-1:0]        free_raddr,
   input  logic [$clog2(DEPTH)-1:0]        key_waddr,
   input  logic [31:0]                     key_wdata,
   input  logic [$clog2(DEPTH)-1:0]        link_waddr,
   input  logic [$clog2(DEPTH+1)-1:0]      link_wdata,
   input  logic [$clog2(DEPTH)-1:0]        free_waddr,
   input  logic [$clog2(DEPTH+1)-1:0]      free_wdata,
   output logic [31:0]                     key_rd,
   output logic [$clog2(DEPTH+1)-1:0]      link_rd,
   output logic [$clog2(DEPTH+1)-1:0]      free_rd
);

   localparam int unsigned PW = $clog2(DEPTH + 1);

   logic [31:0]   key_mem  [DEPTH];
   logic [PW-1:0] link_mem [DEPTH];
   logic [PW-1:0] free_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.key_we) begin
         key_mem[key_waddr] <= key_wdata;
      end
      if (ctl.list_re) begin
         key_rd <= key_mem[list_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (ctl.list_re) begin
         link_rd <= link_mem[list_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.free_we) begin
         free_mem[free_waddr] <= free_wdata;
      end
      if (ctl.free_re) begin
         free_rd <= free_mem[free_raddr];
      end
   end

endmodule

[hw/rtl/sll_seq.sv]
// ----------------------------------------------------------------------------
// sll_seq
// Sequencer: list walk with less-than and not-equal key comparators, relink,
// free list update and result register.
// ----------------------------------------------------------------------------
module sll_seq
   import sll_pkg::*;
#(
   parameter int unsigned DEPTH = SLL_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_opcode,
   input  logic signed [31:0]              req_key,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [1:0]                      rsp_status,
   output logic [3:0]                      rsp_slot,
   output sll_mem_ctl_type                 ctl,
   output logic [$clog2(DEPTH)-1:0]        list_raddr,
   output logic [$clog2(DEPTH)-1:0]        free_raddr,
   output logic [$clog2(DEPTH)-1:0]        key_waddr,
   output logic [31:0]                     key_wdata,
   output logic [$clog2(DEPTH)-1:0]        link_waddr,
   output logic [$clog2(DEPTH+1)-1:0]      link_wdata,
   output logic [$clog2(DEPTH)-1:0]        free_waddr,
   output logic [$clog2(DEPTH+1)-1:0]      free_wdata,
   input  logic [31:0]                     key_rd,
   input  logic [$clog2(DEPTH+1)-1:0]      link_rd,
   input  logic [$clog2(DEPTH+1)-1:0]      free_rd
);

   localparam int unsigned PW = $clog2(DEPTH + 1);
   localparam int unsigned SW = $clog2(DEPTH);
   localparam logic [PW-1:0] NIL = PW'(DEPTH);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_WALK   = 3'd1;
   localparam logic [2:0] S_LINK   = 3'd2;
   localparam logic [2:0] S_LINK2  = 3'd3;
   localparam logic [2:0] S_UNLINK = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [PW-1:0]      head_ff, head_in;
   logic [PW-1:0]      free_head_ff, free_head_in;
   logic [PW-1:0]      fill_ff, fill_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               op_ff, op_in;
   logic signed [31:0] key_ff, key_in;
   logic [PW-1:0]      prev_ff, prev_in;
   logic [PW-1:0]      pres_ff, pres_in;
   logic [1:0]         stat_ff, stat_in;
   logic [PW-1:0]      slot_ff, slot_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [3:0]         rsp_slot_ff, rsp_slot_in;

   logic               live;
   logic               key_lt;
   logic               key_ne;
   logic               advance;
   logic [PW+3:0]      slot_ext;

   assign live     = pres_ff != NIL;
   assign key_lt   = $signed(key_rd) < key_ff;
   assign key_ne   = key_rd != key_ff;
   assign advance  = live && ((op_ff == OP_INSERT) ? key_lt : key_ne);
   assign slot_ext = (PW + 4)'(slot_ff);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      free_head_in  = free_head_ff;
      fill_in       = fill_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      op_in         = op_ff;
      key_in        = key_ff;
      prev_in       = prev_ff;
      pres_in       = pres_ff;
      stat_in       = stat_ff;
      slot_in       = slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      ctl           = '0;
      list_raddr    = head_ff[SW-1:0];
      free_raddr    = free_head_ff[SW-1:0];
      key_waddr     = free_head_ff[SW-1:0];
      key_wdata     = key_ff;
      link_waddr    = free_head_ff[SW-1:0];
      link_wdata    = pres_ff;
      free_waddr    = pres_ff[SW-1:0];
      free_wdata    = free_head_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_opcode;
               key_in  = req_key;
               prev_in = NIL;
               pres_in = head_ff;
               slot_in = '0;
               if (req_opcode == OP_INSERT) begin
                  if (free_head_ff == NIL) begin
                     stat_in  = ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     ctl.list_re = head_ff != NIL;
                     ctl.free_re = free_head_ff != fill_ff;
                     state_in    = S_WALK;
                  end
               end else begin
                  if (head_ff == NIL) begin
                     stat_in  = ST_EMPTY;
                     state_in = S_RESP;
                  end else begin
                     ctl.list_re = 1'b1;
                     state_in    = S_WALK;
                  end
               end
            end
         end
         S_WALK: begin
            if (advance) begin
               prev_in     = pres_ff;
               pres_in     = link_rd;
               ctl.list_re = link_rd != NIL;
               list_raddr  = link_rd[SW-1:0];
            end else if (op_ff == OP_INSERT) begin
               state_in = S_LINK;
            end else if (!live) begin
               stat_in  = ST_MISSING;
               slot_in  = '0;
               state_in = S_RESP;
            end else begin
               state_in = S_UNLINK;
            end
         end
         S_LINK: begin
            ctl.key_we  = 1'b1;
            ctl.link_we = 1'b1;
            // untouched slots form the free list tail in index order
            if (free_head_ff == fill_ff) begin
               free_head_in = free_head_ff + PW'(1);
               fill_in      = fill_ff + PW'(1);
            end else begin
               free_head_in = free_rd;
            end
            stat_in = ST_DONE;
            slot_in = free_head_ff;
            if (prev_ff != NIL) begin
               state_in = S_LINK2;
            end else begin
               head_in  = free_head_ff;
               state_in = S_RESP;
            end
         end
         S_LINK2: begin
            ctl.link_we = 1'b1;
            link_waddr  = prev_ff[SW-1:0];
            link_wdata  = slot_ff;
            state_in    = S_RESP;
         end
         S_UNLINK: begin
            if (prev_ff != NIL) begin
               ctl.link_we = 1'b1;
               link_waddr  = prev_ff[SW-1:0];
               link_wdata  = link_rd;
            end else begin
               head_in = link_rd;
            end
            ctl.free_we  = 1'b1;
            free_head_in = pres_ff;
            stat_in      = ST_DONE;
            slot_in      = pres_ff;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_slot_in   = slot_ext[3:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NIL;
         free_head_ff <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      prev_ff       <= prev_in;
      pres_ff       <= pres_in;
      stat_ff       <= stat_in;
      slot_ff       <= slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule

[hw/rtl/sll_checker.sv]
// ----------------------------------------------------------------------------
// sll_checker
// Port-level checks for the sorted linked list engine, bound to the core.
// ----------------------------------------------------------------------------
module sll_checker
   import sll_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // failed operations report slot zero
   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_DONE |-> rsp_tdata[5:2] == 4'd0)
      else $error("nonzero slot on failure");

   // no result out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind sorted_linked_list_engine_core sll_checker u_sll_checker (.*);
